/* rtl/g711_companding_codec_defines.svh */
// ----------------------------------------------------------------------------
// G.711 codec assertion macros
// Shared property wrappers for the codec RTL; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef G711_COMPANDING_CODEC_DEFINES_SVH
`define G711_COMPANDING_CODEC_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define G711_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define G711_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/g711_pkg.sv */
// ----------------------------------------------------------------------------
// G.711 codec package
// Payload types, law and operation codes and companding constants.
// ----------------------------------------------------------------------------
`default_nettype none

package g711_pkg;

    localparam logic LAW_MU    = 1'b0;
    localparam logic LAW_A     = 1'b1;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic REG_LAW_SELECT = 1'b0;

    localparam logic [15:0] MU_BIAS = 16'd132;
    localparam logic [15:0] A_BIAS  = 16'd8;
    localparam logic [15:0] MAG_MAX = 16'd32767;
    localparam logic [6:0]  A_XOR   = 7'h55;

    typedef struct packed {
        logic               op;
        logic signed [15:0] pcm_in;
        logic        [7:0]  code_in;
    } in_t;

    typedef struct packed {
        logic        [7:0]  code_out;
        logic signed [15:0] pcm_out;
    } out_t;

endpackage

`default_nettype wire

/* rtl/g711_enc.sv */
// ----------------------------------------------------------------------------
// G.711 encoder
// Linear sample to companded byte: bias, saturate, segment search, pack.
// ----------------------------------------------------------------------------
`default_nettype none

module g711_enc
    import g711_pkg::*;
(
    input  wire logic               law,
    input  wire logic signed [15:0] pcm_in,
    output logic             [7:0]  code_out
);

    logic        neg;
    logic [14:0] mag;
    logic [15:0] sum;
    logic [14:0] mag_sat;
    logic [2:0]  seg;
    logic [3:0]  shift;
    logic [14:0] shifted;
    logic [3:0]  mant;

    always_comb
    begin
        neg = pcm_in[15];
        // most negative sample clips to -32767
        if (pcm_in == 16'sh8000)
        begin
            mag = 15'h7FFF;
        end
        else if (neg)
        begin
            mag = 15'(-pcm_in);
        end
        else
        begin
            mag = pcm_in[14:0];
        end

        sum = {1'b0, mag} + ((law == LAW_A) ? A_BIAS : MU_BIAS);
        mag_sat = (sum > MAG_MAX) ? 15'h7FFF : sum[14:0];

        seg = 3'd0;
        if (law == LAW_A)
        begin
            for (int i = 0; i < 7; i++)
            begin
                if (mag_sat[8 + i])
                begin
                    seg = 3'(i + 1);
                end
            end
            shift = (seg == 3'd0) ? 4'd4 : ({1'b0, seg} + 4'd3);
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (mag_sat[7 + i])
                begin
                    seg = 3'(i);
                end
            end
            shift = {1'b0, seg} + 4'd3;
        end

        shifted = mag_sat >> shift;
        mant = shifted[3:0];

        if (law == LAW_A)
        begin
            code_out = {~neg, {seg, mant} ^ A_XOR};
        end
        else
        begin
            code_out = {~neg, ~seg, ~mant};
        end
    end

endmodule

`default_nettype wire

/* rtl/g711_dec.sv */
// ----------------------------------------------------------------------------
// G.711 decoder
// Companded byte to signed Q15 sample: unpack, expand, remove bias, sign.
// ----------------------------------------------------------------------------
`default_nettype none

module g711_dec
    import g711_pkg::*;
(
    input  wire logic              law,
    input  wire logic        [7:0] code_in,
    output logic signed     [15:0] pcm_out
);

    logic [6:0]  body;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic [3:0]  shift;
    logic [15:0] base;
    logic [15:0] expanded;
    logic [15:0] mag;

    always_comb
    begin
        body = (law == LAW_A) ? (code_in[6:0] ^ A_XOR) : ~code_in[6:0];
        seg  = body[6:4];
        mant = body[3:0];

        if ((law == LAW_A) && (seg == 3'd0))
        begin
            base  = {12'd0, mant};
            shift = 4'd4;
        end
        else
        begin
            // implicit leading one above the mantissa
            base  = {11'd0, 1'b1, mant};
            shift = {1'b0, seg} + 4'd3;
        end
        expanded = base << shift;

        if (law == LAW_A)
        begin
            mag = expanded;
        end
        else
        begin
            // remove mu-law bias, floor at zero
            mag = (expanded > MU_BIAS) ? (expanded - MU_BIAS) : 16'd0;
        end

        pcm_out = code_in[7] ? $signed(mag) : $signed(16'd0 - mag);
    end

endmodule

`default_nettype wire

/* rtl/g711_companding_codec.sv */
// An input item is registered in the stage register, then its result in the output register;
// a stall can hold it in either register before the result transfers out.
// Throughput: 1 item per cycle when not stalled; one encoder, one decoder share the single stage.
// A stalled output holds its result while an empty input register can still take one transfer.
// Reset clears both valid flags and sets law_select to mu-law; payloads are not reset.
// ----------------------------------------------------------------------------
// G.711 companding codec
// Mu-law / A-law encode or decode per item, law chosen by an APB register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "g711_companding_codec_defines.svh"

module g711_companding_codec
    import g711_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_t         in_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output out_t             out_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic law_select_reg;
    logic law_select_next;
    logic cfg_write;

    logic s1_valid_reg;
    logic s1_valid_next;
    in_t  s1_data_reg;
    logic s1_load;

    logic out_valid_reg;
    logic out_valid_next;
    out_t out_data_reg;
    out_t out_data_next;
    logic s2_load;

    logic        [7:0]  enc_code;
    logic signed [15:0] dec_pcm;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LAW_SELECT);

    always_comb
    begin
        law_select_next = cfg_write ? pwdata[0] : law_select_reg;
        prdata = (paddr[2] == REG_LAW_SELECT) ? {31'd0, law_select_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_select_reg <= LAW_MU;
        end
        else
        begin
            law_select_reg <= law_select_next;
        end
    end

    // flow control: advance when the next stage is empty or draining
    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_load || (s1_valid_reg && !s2_load);
        out_valid_next = s2_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= in_data;
        end
        if (s2_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    g711_enc u_enc (
        .law      (law_select_reg),
        .pcm_in   (s1_data_reg.pcm_in),
        .code_out (enc_code)
    );

    g711_dec u_dec (
        .law     (law_select_reg),
        .code_in (s1_data_reg.code_in),
        .pcm_out (dec_pcm)
    );

    // zero the field that the operation does not produce
    always_comb
    begin
        if (s1_data_reg.op == OP_DECODE)
        begin
            out_data_next.code_out = 8'd0;
            out_data_next.pcm_out  = dec_pcm;
        end
        else
        begin
            out_data_next.code_out = enc_code;
            out_data_next.pcm_out  = 16'sd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `G711_ASSERT_NEXT(a_stage_to_out, s2_load, out_valid_reg, "stage transfer did not reach output")
    `G711_ASSERT_SAME(a_stall_has_item, in_stall, s1_valid_reg, "input stalled with empty stage")
    `G711_ASSERT_SAME(a_one_field_used, out_valid_reg,
        (out_data_reg.code_out == 8'd0) || (out_data_reg.pcm_out == 16'sd0),
        "both result fields nonzero")
    `G711_ASSERT_NEXT(a_stage_drains, s1_valid_reg && s2_load && !in_valid, !s1_valid_reg,
        "stage kept an item it passed on")

endmodule

`default_nettype wire
